// ===== rtl/amsc_pkg.sv =====
// ----------------------------------------------------------------------------
// amsc_pkg: shared types and constants of the ADC moving average scaler
// Widths of the smoothing path, the scaling datapath and the iterative divider,
// the configuration register indexes and the word types of all channels.
// ----------------------------------------------------------------------------
package amsc_pkg;

  // Configuration of the build
  localparam int MAX_WINDOW  = 16;
  localparam int SAMPLE_BITS = 12;

  // Fixed widths of the words and registers
  localparam int STAMP_W    = 32;
  localparam int VALUE_W    = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int WIN_CFG_W  = 5;

  // Smoothing path widths
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = $clog2(MAX_WINDOW * ((1 << SAMPLE_BITS) - 1) + 1);

  // Scaling datapath widths
  // RMC_W holds raw_min * count and |raw_max - raw_min| * count
  localparam int RMC_W = SAMPLE_BITS + CNT_W;
  localparam int D1_W  = ((SUM_W > RMC_W) ? SUM_W : RMC_W) + 1;
  localparam int DV_W  = VALUE_W + 1;
  localparam int PRD_W = D1_W + DV_W;
  localparam int MAG_W = D1_W + VALUE_W - 1;

  // Divider: quotient bits retired per cycle and iteration count
  localparam int DIV_STEPS = 2;
  localparam int DIV_W     = ((MAG_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int DIV_ITER  = DIV_W / DIV_STEPS;
  localparam int ITER_W    = $clog2(DIV_ITER + 1);
  localparam int RES_W     = DIV_W + 2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAW_MIN   = 3'd0,
    REG_RAW_MAX   = 3'd1,
    REG_VALUE_MIN = 3'd2,
    REG_VALUE_MAX = 3'd3,
    REG_WINDOW    = 3'd4
  } cfg_reg_e;

  // Input word
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] raw_sample;
    logic [STAMP_W-1:0]     stamp_in;
  } amsc_in_t;

  // Output word
  typedef struct packed {
    logic signed [VALUE_W-1:0] scaled_value;
    logic [STAMP_W-1:0]        stamp_out;
  } amsc_out_t;

  // Job handed from the front to the back
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [CNT_W-1:0]   cnt;
    logic [STAMP_W-1:0] stamp;
  } amsc_job_t;

  // Calibration settings seen by the back
  typedef struct packed {
    logic [SAMPLE_BITS-1:0]    raw_min;
    logic [SAMPLE_BITS-1:0]    raw_max;
    logic signed [VALUE_W-1:0] value_min;
    logic signed [VALUE_W-1:0] value_max;
  } amsc_cal_t;

endpackage

// ===== rtl/amsc_ram.sv =====
// ----------------------------------------------------------------------------
// amsc_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module amsc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/amsc_front.sv =====
// ----------------------------------------------------------------------------
// amsc_front: sample intake and running window total
// Accepts sample words, keeps the sample ring, slot, fill count and running
// total, and pushes one job (total, count, stamp) per word into the queue.
// ----------------------------------------------------------------------------
module amsc_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [amsc_pkg::CNT_W-1:0] win_i,
  input  logic                    clear_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  amsc_pkg::amsc_in_t      in_data_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output amsc_pkg::amsc_job_t     q_job_o
);
  import amsc_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE   = 2'b01,
    F_UPDATE = 2'b10
  } front_state_e;

  front_state_e state_q, state_d;
  logic [SLOT_W-1:0]      slot_q, slot_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [SUM_W-1:0]       total_q, total_d;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [STAMP_W-1:0]     stamp_q;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic                   accept;
  logic                   multi;
  logic [CNT_W:0]         slot_inc;

  assign multi      = (win_i > CNT_W'(1));
  assign in_ready_o = (state_q == F_IDLE) && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign slot_inc   = (CNT_W + 1)'(slot_q) + (CNT_W + 1)'(1);

  // Sample ring; the oldest entry is read while the word is accepted
  amsc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == F_UPDATE),
    .waddr_i (slot_q),
    .wdata_i (sample_q),
    .re_i    (accept && multi),
    .raddr_i (slot_q),
    .rdata_o (old_sample)
  );

  // Next state of the window bookkeeping
  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    case (state_q)
      F_IDLE: begin
        if (accept && multi) begin
          state_d = F_UPDATE;
        end
      end
      F_UPDATE: begin
        state_d = F_IDLE;
        if (cnt_q >= win_i) begin
          total_d = total_q - SUM_W'(old_sample) + SUM_W'(sample_q);
        end else begin
          total_d = total_q + SUM_W'(sample_q);
          cnt_d   = cnt_q + CNT_W'(1);
        end
        if (slot_inc >= (CNT_W + 1)'(win_i)) begin
          slot_d = '0;
        end else begin
          slot_d = slot_inc[SLOT_W-1:0];
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
    if (clear_i) begin
      slot_d  = '0;
      cnt_d   = '0;
      total_d = '0;
    end
  end

  // Push a job: at once for a window of one, after the ring update otherwise
  always_comb begin
    if (state_q == F_UPDATE) begin
      q_push_o      = 1'b1;
      q_job_o.sum   = total_d;
      q_job_o.cnt   = cnt_d;
      q_job_o.stamp = stamp_q;
    end else begin
      q_push_o      = accept && !multi;
      q_job_o.sum   = SUM_W'(in_data_i.raw_sample);
      q_job_o.cnt   = CNT_W'(1);
      q_job_o.stamp = in_data_i.stamp_in;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      slot_q  <= '0;
      cnt_q   <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
    end
  end

  // Hold the accepted word for the ring update
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= in_data_i.raw_sample;
      stamp_q  <= in_data_i.stamp_in;
    end
  end

`ifndef SYNTHESIS
  a_cnt_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= win_i)
    else $error("fill count exceeds window");
  a_slot_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    multi |-> (CNT_W + 1)'(slot_q) < (CNT_W + 1)'(win_i))
    else $error("write slot outside window");
`endif

endmodule

// ===== rtl/amsc_fifo.sv =====
// ----------------------------------------------------------------------------
// amsc_fifo: job queue between front and back
// Small register queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module amsc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  amsc_pkg::amsc_job_t job_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output amsc_pkg::amsc_job_t job_o
);
  import amsc_pkg::*;

  amsc_job_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr_q, rptr_q;
  logic [QCNT_W-1:0]  fill_q;

  assign full_o  = (fill_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign job_o   = entry_q[rptr_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= job_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - QCNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/amsc_back.sv =====
// ----------------------------------------------------------------------------
// amsc_back: linear calibration with iterative divide
// Forms numerator and denominator of the mapping, divides with a restoring
// divider retiring DIV_STEPS quotient bits a cycle, saturates and holds the
// result word in the output register.
// ----------------------------------------------------------------------------
module amsc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  amsc_pkg::amsc_cal_t cal_i,
  input  logic                q_valid_i,
  input  amsc_pkg::amsc_job_t q_job_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output amsc_pkg::amsc_out_t out_data_o
);
  import amsc_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MUL  = 4'b0010,
    B_DIV  = 4'b0100,
    B_DONE = 4'b1000
  } back_state_e;

  back_state_e state_q, state_d;
  logic [ITER_W-1:0]        iter_q, iter_d;
  logic                     out_valid_q, out_valid_d;
  amsc_out_t                out_q;

  // Payload registers
  logic signed [D1_W-1:0]   d1_q;
  logic signed [DV_W-1:0]   dv_q;
  logic [RMC_W-1:0]         den_q;
  logic                     dneg_q;
  logic                     eq_q;
  logic                     neg_q;
  logic [STAMP_W-1:0]       stamp_q;
  logic [DIV_W-1:0]         dvd_q, dvd_n;
  logic [RMC_W-1:0]         rem_q, rem_n;

  // Setup terms
  logic [RMC_W-1:0]           rmin_c;
  logic signed [D1_W-1:0]     d1;
  logic signed [SAMPLE_BITS:0] dr;
  logic [SAMPLE_BITS-1:0]     dr_mag;
  logic [RMC_W-1:0]           den;
  logic signed [DV_W-1:0]     dv;

  // Multiply terms
  logic signed [PRD_W-1:0]  prod;
  logic [PRD_W-1:0]         prod_mag;

  // Divide step
  logic [RMC_W:0]           trial;

  // Final terms
  logic signed [RES_W-1:0]  q_ext;
  logic signed [RES_W-1:0]  q_sgn;
  logic signed [RES_W-1:0]  res;
  logic signed [RES_W-1:0]  sat_hi;
  logic signed [RES_W-1:0]  sat_lo;
  logic signed [VALUE_W-1:0] result;
  logic                     load_out;

  assign q_pop_o     = (state_q == B_IDLE) && q_valid_i;
  assign load_out    = (state_q == B_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Offset numerator, denominator magnitude and value span from the queue head
  always_comb begin
    rmin_c = RMC_W'(cal_i.raw_min) * RMC_W'(q_job_i.cnt);
    d1     = $signed(D1_W'(q_job_i.sum)) - $signed(D1_W'(rmin_c));
    dr     = $signed({1'b0, cal_i.raw_max}) - $signed({1'b0, cal_i.raw_min});
    dr_mag = dr[SAMPLE_BITS] ? SAMPLE_BITS'(-dr) : dr[SAMPLE_BITS-1:0];
    den    = RMC_W'(dr_mag) * RMC_W'(q_job_i.cnt);
    dv     = $signed({cal_i.value_max[VALUE_W-1], cal_i.value_max})
           - $signed({cal_i.value_min[VALUE_W-1], cal_i.value_min});
  end

  // Full numerator and its magnitude
  always_comb begin
    prod     = d1_q * dv_q;
    prod_mag = prod[PRD_W-1] ? PRD_W'(-prod) : PRD_W'(prod);
  end

  // Restoring divide, DIV_STEPS quotient bits per cycle
  always_comb begin
    rem_n = rem_q;
    dvd_n = dvd_q;
    trial = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {rem_n, dvd_n[DIV_W-1]};
      dvd_n = {dvd_n[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial    = trial - {1'b0, den_q};
        dvd_n[0] = 1'b1;
      end
      rem_n = trial[RMC_W-1:0];
    end
  end

  // Apply sign, add offset and saturate; equal raw codes give value_min
  always_comb begin
    sat_hi = {{(RES_W - VALUE_W + 1){1'b0}}, {(VALUE_W - 1){1'b1}}};
    sat_lo = {{(RES_W - VALUE_W + 1){1'b1}}, {(VALUE_W - 1){1'b0}}};
    q_ext  = $signed({2'b00, dvd_q});
    q_sgn  = neg_q ? -q_ext : q_ext;
    res    = RES_W'(cal_i.value_min) + q_sgn;
    if (eq_q) begin
      result = cal_i.value_min;
    end else if (res > sat_hi) begin
      result = sat_hi[VALUE_W-1:0];
    end else if (res < sat_lo) begin
      result = sat_lo[VALUE_W-1:0];
    end else begin
      result = res[VALUE_W-1:0];
    end
  end

  // Sequence one job through multiply, divide and output
  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          state_d = B_MUL;
        end
      end
      B_MUL: begin
        state_d = B_DIV;
        iter_d  = '0;
      end
      B_DIV: begin
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(DIV_ITER - 1)) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (load_out) begin
          state_d     = B_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      d1_q    <= d1;
      dv_q    <= dv;
      den_q   <= den;
      dneg_q  <= dr[SAMPLE_BITS];
      eq_q    <= (cal_i.raw_max == cal_i.raw_min);
      stamp_q <= q_job_i.stamp;
    end
    if (state_q == B_MUL) begin
      dvd_q <= DIV_W'(prod_mag[MAG_W-1:0]);
      rem_q <= '0;
      neg_q <= prod[PRD_W-1] ^ dneg_q;
    end else if (state_q == B_DIV) begin
      dvd_q <= dvd_n;
      rem_q <= rem_n;
    end
    if (load_out) begin
      out_q.scaled_value <= result;
      out_q.stamp_out    <= stamp_q;
    end
  end

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV && !eq_q) |-> rem_q < den_q)
    else $error("divider remainder not below divisor");
`endif

endmodule

// ===== rtl/adc_moving_average_scaler_unit.sv =====
// A sample word passes the front, the job queue and the back; when averaging, the front
//   first updates the ring and total in its F_UPDATE state before it pushes the job.
// The front may accept further words while the back is busy, up to the queue depth;
//   the divider retires DIV_STEPS quotient bits a cycle and serves one job at a time.
// Reset: clears control state and restores the default calibration and a
//   window of one; the sample ring is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// adc_moving_average_scaler_unit: smoothed, calibrated ADC reading
// Front keeps the moving window total, a small queue decouples it from the
// back, which maps the average linearly into signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
module adc_moving_average_scaler_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [amsc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [amsc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  amsc_pkg::amsc_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output amsc_pkg::amsc_out_t                 out_data_o
);
  import amsc_pkg::*;

  amsc_cal_t              cal_q;
  logic [CNT_W-1:0]       win_q;
  logic [WIN_CFG_W-1:0]   win_wr;
  logic [CNT_W-1:0]       win_d;
  logic                   win_clear;
  logic                   q_push, q_full, q_pop, q_valid;
  amsc_job_t              q_in, q_out;

  // Clamp a written window into one to MAX_WINDOW
  always_comb begin
    win_wr = cfg_wdata_i[WIN_CFG_W-1:0];
    if (win_wr == '0) begin
      win_d = CNT_W'(1);
    end else if (int'(win_wr) > MAX_WINDOW) begin
      win_d = CNT_W'(MAX_WINDOW);
    end else begin
      win_d = CNT_W'(win_wr);
    end
  end

  assign win_clear = cfg_we_i && (cfg_index_i == REG_WINDOW);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q.raw_min   <= '0;
      cal_q.raw_max   <= {SAMPLE_BITS{1'b1}};
      cal_q.value_min <= '0;
      cal_q.value_max <= VALUE_W'(65536);
      win_q           <= CNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_RAW_MIN:   cal_q.raw_min   <= cfg_wdata_i[SAMPLE_BITS-1:0];
        REG_RAW_MAX:   cal_q.raw_max   <= cfg_wdata_i[SAMPLE_BITS-1:0];
        REG_VALUE_MIN: cal_q.value_min <= cfg_wdata_i[VALUE_W-1:0];
        REG_VALUE_MAX: cal_q.value_max <= cfg_wdata_i[VALUE_W-1:0];
        REG_WINDOW:    win_q           <= win_d;
        default: begin
        end
      endcase
    end
  end

  amsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .win_i      (win_q),
    .clear_i    (win_clear),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_in)
  );

  amsc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_out)
  );

  amsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cal_i       (cal_q),
    .q_valid_i   (q_valid),
    .q_job_i     (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== verif/tb_adc_moving_average_scaler_unit.sv =====
// ----------------------------------------------------------------------------
// tb_adc_moving_average_scaler_unit: self-checking bench of the ADC scaler
// Feeds sample words through a valid/ready driver and checks every result word
// against a cycle-free model of the moving window and the Q16.16 calibration.
// Runs a directed set of corner cases, then random calibrations and windows
// with random gaps and stalls on both channels and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_adc_moving_average_scaler_unit;
  import amsc_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 12;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 60;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int RAND_PHASES     = 18;
  localparam int WORDS_PER_PHASE = 52;
  localparam int HOLD_PHASE      = 3;

  localparam logic [SAMPLE_BITS-1:0] MAX_CODE   = '1;
  localparam logic [CFG_IDX_W-1:0]   REG_UNUSED = REG_WINDOW + 1'b1;
  localparam longint SAT_HI = (longint'(1) <<< (VALUE_W - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) <<< (VALUE_W - 1));

  // Block ports
  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  amsc_in_t               in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  amsc_out_t              out_data_o;

  // Calibration and window as the block should hold them
  logic [SAMPLE_BITS-1:0]    cal_raw_min   = '0;
  logic [SAMPLE_BITS-1:0]    cal_raw_max   = MAX_CODE;
  logic signed [VALUE_W-1:0] cal_value_min = '0;
  logic signed [VALUE_W-1:0] cal_value_max = 32'sd65536;
  logic [CNT_W-1:0]          avg_window    = CNT_W'(1);

  // Sample history of the moving window
  logic [SAMPLE_BITS-1:0] hist_ring [MAX_WINDOW];
  logic [SLOT_W-1:0]      hist_slot  = '0;
  logic [CNT_W-1:0]       hist_fill  = '0;
  logic [SUM_W-1:0]       hist_total = '0;

  // Words waiting to be sent and readings waiting to come back
  amsc_in_t  pending_words [$];
  amsc_out_t readings_due  [$];

  int   mismatch_count = 0;
  int   stall_cycles   = 0;
  int   send_gap       = 0;
  int   rx_stall       = 0;
  bit   in_taken       = 1'b0;
  bit   idle_on        = 1'b1;
  bit   rx_hold_req    = 1'b0;
  logic [STAMP_W-1:0] stamp_base = '0;

  adc_moving_average_scaler_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Track a register write in the expected settings
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    logic [WIN_CFG_W-1:0] w;
    w = data[WIN_CFG_W-1:0];
    case (idx)
      REG_RAW_MIN:   cal_raw_min   = data[SAMPLE_BITS-1:0];
      REG_RAW_MAX:   cal_raw_max   = data[SAMPLE_BITS-1:0];
      REG_VALUE_MIN: cal_value_min = data[VALUE_W-1:0];
      REG_VALUE_MAX: cal_value_max = data[VALUE_W-1:0];
      REG_WINDOW: begin
        // clamp to 1..MAX_WINDOW and restart the history
        if (w == '0) begin
          avg_window = CNT_W'(1);
        end else if (w > MAX_WINDOW) begin
          avg_window = CNT_W'(MAX_WINDOW);
        end else begin
          avg_window = CNT_W'(w);
        end
        hist_slot  = '0;
        hist_fill  = '0;
        hist_total = '0;
      end
      default: ;
    endcase
  endfunction

  // Advance the window with one sample and return its calibrated average
  function automatic logic signed [VALUE_W-1:0] smooth_and_scale(
      logic [SAMPLE_BITS-1:0] sample);
    longint sum, cnt, num, den, res;
    sum = longint'(sample);
    cnt = 1;
    if (avg_window > 1) begin
      if (hist_fill >= avg_window) begin
        hist_total = hist_total - hist_ring[hist_slot];
      end else begin
        hist_fill = hist_fill + 1'b1;
      end
      hist_ring[hist_slot] = sample;
      hist_total = hist_total + sample;
      if (CNT_W'(hist_slot) + 1'b1 >= avg_window) begin
        hist_slot = '0;
      end else begin
        hist_slot = hist_slot + 1'b1;
      end
      sum = longint'(hist_total);
      cnt = longint'(hist_fill);
    end
    if (cal_raw_max == cal_raw_min) begin
      res = longint'(cal_value_min);
    end else begin
      num = (sum - longint'(cal_raw_min) * cnt)
            * (longint'(cal_value_max) - longint'(cal_value_min));
      den = cnt * (longint'(cal_raw_max) - longint'(cal_raw_min));
      res = longint'(cal_value_min) + num / den;
    end
    if (res > SAT_HI) res = SAT_HI;
    if (res < SAT_LO) res = SAT_LO;
    return VALUE_W'(res);
  endfunction

  // Mostly short gaps, some medium, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Pick a sample: extremes, near the calibration codes, or uniform
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? MAX_CODE : '0;
      1: v = int'(cal_raw_min) + int'($urandom_range(0, 16)) - 8;
      2: v = int'(cal_raw_max) + int'($urandom_range(0, 16)) - 8;
      default: return SAMPLE_BITS'($urandom);
    endcase
    if (v < 0) v = 0;
    if (v > int'(MAX_CODE)) v = int'(MAX_CODE);
    return SAMPLE_BITS'(v);
  endfunction

  task automatic queue_word(logic [SAMPLE_BITS-1:0] sample, logic [STAMP_W-1:0] stamp);
    pending_words.push_back('{raw_sample: sample, stamp_in: stamp});
  endtask

  // Write one register; call only while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every queued word is sent and every reading is back
  task automatic drain();
    while (pending_words.size() != 0 || in_valid_i || readings_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Choose a fresh calibration and window for one random phase
  task automatic randomize_setup();
    logic [CFG_DATA_W-1:0] lo, hi, r;
    r = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 4))
        0: begin lo = '0;       hi = MAX_CODE; end
        1: begin lo = MAX_CODE; hi = '0;       end
        2: begin lo = $urandom; hi = {r[31:SAMPLE_BITS], lo[SAMPLE_BITS-1:0]}; end
        3: begin lo = $urandom_range(0, 500); hi = $urandom_range(3500, MAX_CODE); end
        default: begin lo = $urandom; hi = $urandom; end
      endcase
      write_reg(REG_RAW_MIN, lo);
      write_reg(REG_RAW_MAX, hi);
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 4))
        0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
        1: begin lo = 32'h7FFF_FFFF; hi = 32'h8000_0000; end
        2: begin lo = $urandom;      hi = lo;            end
        3: begin
          lo = {{12{r[19]}}, r[19:0]};
          r  = $urandom;
          hi = {{12{r[19]}}, r[19:0]};
        end
        default: begin lo = $urandom; hi = $urandom; end
      endcase
      write_reg(REG_VALUE_MIN, lo);
      write_reg(REG_VALUE_MAX, hi);
    end
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 5))
        0: lo = 1;
        1: lo = MAX_WINDOW;
        2: lo = '0;
        3: lo = $urandom;
        default: lo = $urandom_range(2, MAX_WINDOW - 1);
      endcase
      write_reg(REG_WINDOW, lo);
    end
    if ($urandom_range(0, 7) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED, (1 << CFG_IDX_W) - 1)), $urandom);
    end
  endtask

  // Driver: present the next sample word, hold it until taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        in_taken = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_words[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_stall    = HOLD_CYCLES;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        rx_stall = pick_gap() - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: predict on each sent word, check each result word
  always @(posedge clk_i) begin : monitor
    amsc_out_t due;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        due.scaled_value = smooth_and_scale(in_data_i.raw_sample);
        due.stamp_out    = in_data_i.stamp_in;
        readings_due.push_back(due);
        void'(pending_words.pop_front());
        in_taken = 1'b1;
        if (idle_on && $urandom_range(0, 1) == 0) send_gap = pick_gap();
      end
      if (out_valid_o && out_ready_i) begin
        if (readings_due.size() == 0) begin
          $error("scaled_value: unexpected result word, got %0d (stamp_out 0x%08h)",
                 out_data_o.scaled_value, out_data_o.stamp_out);
          mismatch_count++;
        end else begin
          due = readings_due.pop_front();
          if (out_data_o.scaled_value !== due.scaled_value) begin
            $error("scaled_value mismatch: expected %0d, got %0d",
                   due.scaled_value, out_data_o.scaled_value);
            mismatch_count++;
          end
          if (out_data_o.stamp_out !== due.stamp_out) begin
            $error("stamp_out mismatch: expected 0x%08h, got 0x%08h",
                   due.stamp_out, out_data_o.stamp_out);
            mismatch_count++;
          end
        end
      end
      // Watchdog: count cycles without any word moving
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset calibration, window of one: field extremes and bit patterns
    queue_word('0, '0);
    queue_word(MAX_CODE, '1);
    queue_word(12'hAAA, 32'hAAAA_AAAA);
    queue_word(12'h555, 32'h5555_5555);
    queue_word(12'h800, 32'h8000_0000);
    drain();

    // Equal calibration codes give value_min
    write_reg(REG_RAW_MIN, 100);
    write_reg(REG_RAW_MAX, 100);
    write_reg(REG_VALUE_MIN, -32'sd327680);
    queue_word('0, 32'd1);
    queue_word(MAX_CODE, 32'd2);
    queue_word(12'd100, 32'd3);
    drain();

    // Reversed calibration over the full value span
    write_reg(REG_RAW_MIN, MAX_CODE);
    write_reg(REG_RAW_MAX, 0);
    write_reg(REG_VALUE_MIN, 32'h7FFF_FFFF);
    write_reg(REG_VALUE_MAX, 32'h8000_0000);
    queue_word('0, 32'd4);
    queue_word(MAX_CODE, 32'd5);
    queue_word(12'd1, 32'd6);
    queue_word(12'd2048, 32'd7);
    drain();

    // Steep gain: saturate high, then low
    write_reg(REG_RAW_MIN, 0);
    write_reg(REG_RAW_MAX, 1);
    write_reg(REG_VALUE_MIN, 0);
    write_reg(REG_VALUE_MAX, 32'h7FFF_FFFF);
    queue_word(MAX_CODE, 32'd8);
    queue_word('0, 32'd9);
    queue_word(12'd1, 32'd10);
    drain();
    write_reg(REG_VALUE_MAX, 32'h8000_0000);
    queue_word(MAX_CODE, 32'd11);
    drain();

    // Window of zero acts as one; unused index and upper data bits ignored
    write_reg(REG_RAW_MAX, 32'hFFFF_FFFF);
    write_reg(REG_VALUE_MAX, 32'h0001_0000);
    write_reg(REG_WINDOW, 0);
    write_reg(REG_UNUSED, '1);
    queue_word(12'd1000, 32'd12);
    queue_word(12'd3000, 32'd13);
    drain();

    // Window above the maximum clamps to the full ring
    write_reg(REG_WINDOW, 31);
    queue_word(MAX_CODE, 32'd14);
    queue_word('0, 32'd15);
    queue_word(12'd7, 32'd16);
    drain();

    // Window of two: ring wraps and drops the oldest sample
    write_reg(REG_WINDOW, 2);
    queue_word(12'd10, 32'd17);
    queue_word(12'd20, 32'd18);
    queue_word(12'd4000, 32'd19);
    queue_word(MAX_CODE, 32'd20);
    drain();

    // Random calibrations and windows
    for (int p = 0; p < RAND_PHASES; p++) begin
      randomize_setup();
      idle_on = ($urandom_range(0, 3) != 0);
      @(posedge clk_i);
      if (p == HOLD_PHASE) begin
        // keep offering words while the output holds off
        idle_on     = 1'b0;
        rx_hold_req = 1'b1;
      end
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if ($urandom_range(0, 1) == 0) begin
          stamp_base = stamp_base + $urandom_range(1, 3);
          queue_word(pick_sample(), stamp_base);
        end else begin
          queue_word(pick_sample(), $urandom);
        end
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && readings_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
